### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. In synthesis both forms expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every rising edge outside reset.
`define LBL_ASSERT(name, clock, reset_n, prop, msg) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (prop)) \
        else $error(msg);

// Checks that a condition never occurs at a rising edge outside reset.
`define LBL_ASSERT_NEVER(name, clock, reset_n, cond, msg) \
    name: assert property (@(posedge clock) disable iff (!reset_n) !(cond)) \
        else $error(msg);

`else

`define LBL_ASSERT(name, clock, reset_n, prop, msg)
`define LBL_ASSERT_NEVER(name, clock, reset_n, cond, msg)

`endif

`endif

### hw/rtl/lbl_pkg.sv
package lbl_pkg;

    // Kinds of input item.
    localparam logic [1:0] KIND_INIT    = 2'd0;
    localparam logic [1:0] KIND_SET_LED = 2'd1;
    localparam logic [1:0] KIND_RX_PKT  = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_OP_ACK          = 3'd0;
    localparam logic [2:0] REG_OP_BUTTON_EVENT = 3'd1;
    localparam logic [2:0] REG_OP_BOARD_RESET  = 3'd2;
    localparam logic [2:0] REG_OP_BUTTONS_ON   = 3'd3;
    localparam logic [2:0] REG_OP_LED_SET      = 3'd4;
    localparam logic [2:0] REG_OP_LED_USER     = 3'd5;

    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 32;

    // Seven-segment font for the sixteen hex digits.
    localparam logic [7:0] HEX_FONT [16] = '{
        8'hE7, 8'h06, 8'hCB, 8'h8F, 8'h2E, 8'hAD, 8'hED, 8'h86,
        8'hEF, 8'hAF, 8'hEE, 8'h6D, 8'hE1, 8'h4F, 8'hE9, 8'hE8
    };

    typedef struct packed {
        logic [7:0] op_ack;
        logic [7:0] op_button_event;
        logic [7:0] op_board_reset;
        logic [7:0] op_buttons_on;
        logic [7:0] op_led_set;
        logic [7:0] op_led_user;
    } cfg_t;

    // One classified item, waiting for the transmit sequencer.
    typedef struct packed {
        logic        init;
        logic        leds;
        logic        accepted;
        logic [7:0]  buttons;
        logic [31:0] word;
    } q_entry_t;

endpackage

### hw/rtl/lbl_regs.sv
module lbl_regs
    import lbl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.op_ack          <= 8'd64;
            cfg_reg.op_button_event <= 8'd65;
            cfg_reg.op_board_reset  <= 8'd70;
            cfg_reg.op_buttons_on   <= 8'd3;
            cfg_reg.op_led_set      <= 8'd5;
            cfg_reg.op_led_user     <= 8'd7;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_OP_ACK:          cfg_reg.op_ack          <= pwdata[7:0];
                REG_OP_BUTTON_EVENT: cfg_reg.op_button_event <= pwdata[7:0];
                REG_OP_BOARD_RESET:  cfg_reg.op_board_reset  <= pwdata[7:0];
                REG_OP_BUTTONS_ON:   cfg_reg.op_buttons_on   <= pwdata[7:0];
                REG_OP_LED_SET:      cfg_reg.op_led_set      <= pwdata[7:0];
                REG_OP_LED_USER:     cfg_reg.op_led_user     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_OP_ACK:          prdata = {24'd0, cfg_reg.op_ack};
            REG_OP_BUTTON_EVENT: prdata = {24'd0, cfg_reg.op_button_event};
            REG_OP_BOARD_RESET:  prdata = {24'd0, cfg_reg.op_board_reset};
            REG_OP_BUTTONS_ON:   prdata = {24'd0, cfg_reg.op_buttons_on};
            REG_OP_LED_SET:      prdata = {24'd0, cfg_reg.op_led_set};
            REG_OP_LED_USER:     prdata = {24'd0, cfg_reg.op_led_user};
            default:             prdata = '0;
        endcase
    end

endmodule

### hw/rtl/lbl_front.sv
module lbl_front
    import lbl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] led_word,
    input  logic [7:0]  rx_opcode,
    input  logic [7:0]  rx_second,
    input  logic [7:0]  rx_third,
    input  logic        q_full,
    output logic        q_push,
    output q_entry_t    q_entry
);

    logic        ack_seen_reg, ack_seen_next;
    logic [31:0] saved_word_reg, saved_word_next;
    logic [7:0]  button_reg, button_next;
    logic [3:0]  rdlu;
    logic [3:0]  rldu;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // Button bytes arrive active low; the direction nibble is reordered to R L D U.
    assign rdlu = ~rx_third[3:0];
    assign rldu = {rdlu[3], rdlu[1], rdlu[2], rdlu[0]};

    always_comb
    begin
        ack_seen_next    = ack_seen_reg;
        saved_word_next  = saved_word_reg;
        button_next      = button_reg;
        q_entry.init     = 1'b0;
        q_entry.leds     = 1'b0;
        q_entry.accepted = 1'b0;
        q_entry.word     = led_word;

        case (kind)
            KIND_INIT:
            begin
                ack_seen_next   = 1'b0;
                saved_word_next = '0;
                button_next     = '0;
                q_entry.init    = 1'b1;
            end
            KIND_SET_LED:
            begin
                if (ack_seen_reg)
                begin
                    ack_seen_next    = 1'b0;
                    saved_word_next  = led_word;
                    q_entry.leds     = 1'b1;
                    q_entry.accepted = 1'b1;
                end
            end
            KIND_RX_PKT:
            begin
                if (rx_opcode == cfg.op_ack)
                begin
                    ack_seen_next = 1'b1;
                end
                else if (rx_opcode == cfg.op_button_event)
                begin
                    button_next = {rldu, ~rx_second[3:0]};
                end
                else if (rx_opcode == cfg.op_board_reset)
                begin
                    // Reinitialize, then resend the saved word; it stays saved.
                    ack_seen_next    = 1'b0;
                    button_next      = '0;
                    q_entry.init     = 1'b1;
                    q_entry.leds     = 1'b1;
                    q_entry.accepted = 1'b1;
                    q_entry.word     = saved_word_reg;
                end
            end
            default: ;
        endcase

        q_entry.buttons = button_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_seen_reg   <= 1'b0;
            saved_word_reg <= '0;
            button_reg     <= '0;
        end
        else if (q_push)
        begin
            ack_seen_reg   <= ack_seen_next;
            saved_word_reg <= saved_word_next;
            button_reg     <= button_next;
        end
    end

endmodule

### hw/rtl/lbl_queue.sv
module lbl_queue
    import lbl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output q_entry_t head
);

    q_entry_t   mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### hw/rtl/lbl_back.sv
`include "assert_macros.svh"

module lbl_back
    import lbl_pkg::*;
#(
    parameter int DIGITS = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       head_valid,
    input  q_entry_t   head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       last,
    output logic [7:0] buttons,
    output logic       led_accepted
);

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_INIT1,
        PH_USER,
        PH_SET,
        PH_MASK,
        PH_DIGIT
    } phase_t;

    localparam logic [3:0] DIGIT_MASK = 4'((1 << DIGITS) - 1);

    phase_t     phase_reg, phase_next;
    logic [3:0] dmask_reg, dmask_next;
    logic       out_valid_reg;
    logic       tx_valid_reg;
    logic [7:0] tx_byte_reg;
    logic       last_reg;
    logic [7:0] buttons_reg;
    logic       led_accepted_reg;

    logic       emit;
    logic       b_tx;
    logic [7:0] b_byte;
    logic       b_last;
    logic [3:0] en;
    logic [1:0] idx;
    logic [3:0] dmask_left;

    assign emit = head_valid && (!out_valid_reg || !out_stall);
    assign pop  = emit && b_last;
    assign en   = head.word[19:16] & DIGIT_MASK;

    // Lowest enabled digit still to send.
    always_comb
    begin
        idx = 2'd0;
        for (int i = 3; i >= 0; i--)
        begin
            if (dmask_reg[i])
            begin
                idx = 2'(i);
            end
        end
    end

    assign dmask_left = dmask_reg & ~(4'b0001 << idx);

    always_comb
    begin
        phase_next = phase_reg;
        dmask_next = dmask_reg;
        b_tx       = 1'b1;
        b_byte     = '0;
        b_last     = 1'b0;

        case (phase_reg)
            PH_FIRST:
            begin
                if (head.init)
                begin
                    b_byte     = cfg.op_buttons_on;
                    phase_next = PH_INIT1;
                end
                else if (head.leds)
                begin
                    b_byte     = cfg.op_led_user;
                    phase_next = PH_SET;
                end
                else
                begin
                    b_tx   = 1'b0;
                    b_last = 1'b1;
                end
            end
            PH_INIT1:
            begin
                b_byte = cfg.op_led_user;
                if (head.leds)
                begin
                    phase_next = PH_USER;
                end
                else
                begin
                    b_last     = 1'b1;
                    phase_next = PH_FIRST;
                end
            end
            PH_USER:
            begin
                b_byte     = cfg.op_led_user;
                phase_next = PH_SET;
            end
            PH_SET:
            begin
                b_byte     = cfg.op_led_set;
                phase_next = PH_MASK;
            end
            PH_MASK:
            begin
                b_byte     = {4'd0, en};
                dmask_next = en;
                if (en == 4'd0)
                begin
                    b_last     = 1'b1;
                    phase_next = PH_FIRST;
                end
                else
                begin
                    phase_next = PH_DIGIT;
                end
            end
            PH_DIGIT:
            begin
                b_byte     = HEX_FONT[head.word[4*idx +: 4]]
                           | {3'd0, head.word[24 + idx], 4'd0};
                dmask_next = dmask_left;
                if (dmask_left == 4'd0)
                begin
                    b_last     = 1'b1;
                    phase_next = PH_FIRST;
                end
            end
            default:
            begin
                phase_next = PH_FIRST;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_FIRST;
            dmask_reg        <= '0;
            out_valid_reg    <= 1'b0;
            tx_valid_reg     <= 1'b0;
            tx_byte_reg      <= '0;
            last_reg         <= 1'b0;
            buttons_reg      <= '0;
            led_accepted_reg <= 1'b0;
        end
        else if (emit)
        begin
            phase_reg        <= phase_next;
            dmask_reg        <= dmask_next;
            out_valid_reg    <= 1'b1;
            tx_valid_reg     <= b_tx;
            tx_byte_reg      <= b_byte;
            last_reg         <= b_last;
            buttons_reg      <= head.buttons;
            led_accepted_reg <= head.accepted;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tx_valid     = tx_valid_reg;
    assign tx_byte      = tx_byte_reg;
    assign last         = last_reg;
    assign buttons      = buttons_reg;
    assign led_accepted = led_accepted_reg;

    `LBL_ASSERT(a_mid_entry_held, clk, rst_n, (phase_reg != PH_FIRST) |-> head_valid, "entry popped mid-sequence")
    `LBL_ASSERT_NEVER(a_digit_mask_live, clk, rst_n, (phase_reg == PH_DIGIT) && (dmask_reg == 4'd0), "digit phase with no digits left")
    `LBL_ASSERT(a_empty_is_last, clk, rst_n, (out_valid_reg && !tx_valid_reg) |-> last_reg, "empty result not marked last")
    `LBL_ASSERT(a_accept_sends, clk, rst_n, (out_valid_reg && led_accepted_reg) |-> tx_valid_reg, "accepted LED item without a byte")

endmodule

### hw/rtl/led_button_link_controller.sv
// Link controller for a keypad and seven-segment board. Each input transfer is an init
// request, a set-LED request or one received three-byte packet, and each output transfer
// carries one byte for the serial link; an item that sends nothing still yields one
// output transfer with tx_valid low and last high. A front stage classifies items and
// keeps the ack flag, the saved LED word and the button byte, and pushes a descriptor
// into a two-entry queue. A back sequencer then emits the item's bytes through an output
// register, one per cycle unless out_stall holds it. An item sends up to nine bytes and
// yields one output transfer per byte it sends (at least one), and the front takes a new
// item every cycle while the queue has room, so bursts of short items enter back to back.
// Opcode registers sit at byte addresses 0, 4, 8, 12, 16 and 20 on the APB port and should
// only be written while no item is in flight.
module led_button_link_controller
    import lbl_pkg::*;
#(
    parameter int DIGITS = 4
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [31:0]        led_word,
    input  logic [7:0]         rx_opcode,
    input  logic [7:0]         rx_second,
    input  logic [7:0]         rx_third,

    output logic               out_valid,
    input  logic               out_stall,
    output logic               tx_valid,
    output logic [7:0]         tx_byte,
    output logic               last,
    output logic [7:0]         buttons,
    output logic               led_accepted
);

    cfg_t     cfg;
    logic     q_full;
    logic     q_push;
    q_entry_t q_in;
    logic     q_pop;
    logic     q_head_valid;
    q_entry_t q_head;

    // Opcode registers.
    lbl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front: takes items, updates the link state and decides what is to be sent.
    lbl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .led_word  (led_word),
        .rx_opcode (rx_opcode),
        .rx_second (rx_second),
        .rx_third  (rx_third),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    // Descriptor queue that lets the front run ahead of a stalled output.
    lbl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    // Back: walks each descriptor and sends its bytes, one transfer per cycle unless the output is stalled.
    lbl_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head_valid   (q_head_valid),
        .head         (q_head),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tx_valid     (tx_valid),
        .tx_byte      (tx_byte),
        .last         (last),
        .buttons      (buttons),
        .led_accepted (led_accepted)
    );

endmodule
